// File: hdl/ternary_band_range_cover_macros.svh
// assertion macros shared by the checker
`ifndef TERNARY_BAND_RANGE_COVER_MACROS_SVH
`define TERNARY_BAND_RANGE_COVER_MACROS_SVH

// same-cycle implication
`define TBRC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tbrc: property failed");

// next-cycle implication
`define TBRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tbrc: property failed");

`endif

// File: hdl/tbrc_pkg.sv
package tbrc_pkg;

   localparam int BAND_WIDTH     = 4;
   localparam int MAX_BAND_COUNT = 8;

   localparam int DATA_WIDTH  = 32;
   localparam int MASK_WIDTH  = 8;
   localparam int COUNT_WIDTH = 4;
   localparam int CMD_WIDTH   = 2;

   localparam int FIT_BANDS  = (DATA_WIDTH + BAND_WIDTH - 1) / BAND_WIDTH;
   localparam int BAND_SLOTS = (MAX_BAND_COUNT < FIT_BANDS) ? MAX_BAND_COUNT : FIT_BANDS;

   localparam logic [CMD_WIDTH-1:0] CMD_OVERLAP   = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_MIN_COVER = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_MAX_COVER = 2'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED    = 2'd3;

   // bits of one band, clipped to the data word
   function automatic logic [DATA_WIDTH-1:0] band_field_mask(input int idx);
      logic [2*DATA_WIDTH-1:0] full;
      full = ((((2*DATA_WIDTH)'(1)) << BAND_WIDTH) - (2*DATA_WIDTH)'(1)) << (idx * BAND_WIDTH);
      if (idx * BAND_WIDTH >= DATA_WIDTH) begin
         return '0;
      end
      return full[DATA_WIDTH-1:0];
   endfunction

endpackage

// File: hdl/ternary_band_range_cover.sv
// a word accepted on req is registered in the input stage, then in the result stage, and shown on rsp
// throughput: one word per cycle; req_stall rises only while a result waits on a stalled rsp
// the band search, carry and borrow chains sit between the input and result registers
// reset is synchronous and active high: it empties both stages, payload is not cleared
module ternary_band_range_cover
   import tbrc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [CMD_WIDTH-1:0]   req_command,
   input  logic [DATA_WIDTH-1:0]  req_range_lo,
   input  logic [DATA_WIDTH-1:0]  req_range_hi,
   input  logic [DATA_WIDTH-1:0]  req_pattern_value,
   input  logic [MASK_WIDTH-1:0]  req_band_mask,
   input  logic [COUNT_WIDTH-1:0] req_band_count,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [DATA_WIDTH-1:0]  rsp_out_lo,
   output logic [DATA_WIDTH-1:0]  rsp_out_hi,
   output logic                   rsp_ok_flag
);

   typedef struct packed {
      logic                  hit;
      logic                  found;
      logic [DATA_WIDTH-1:0] value;
   } border_type;

   // left border of the next bank, or right border of the previous bank
   function automatic border_type seek_border(
      input logic [DATA_WIDTH-1:0] p,
      input logic [DATA_WIDTH-1:0] val,
      input logic [DATA_WIDTH-1:0] below,
      input logic [BAND_SLOTS-1:0] fixed,
      input logic [BAND_SLOTS-1:0] wild,
      input logic                  right
   );
      border_type              res;
      logic [BAND_SLOTS-1:0]   diff;
      logic [BAND_SLOTS-1:0]   sel;
      logic [BAND_SLOTS-1:0]   reach;
      logic [BAND_SLOTS:0]     carry;
      logic                    seen;
      logic                    go;
      logic                    full;
      logic [DATA_WIDTH-1:0]   m;
      logic [DATA_WIDTH-1:0]   pb;
      logic [DATA_WIDTH-1:0]   vb;
      logic [DATA_WIDTH-1:0]   one;
      logic [DATA_WIDTH-1:0]   x;
      seen = 1'b0;
      go   = 1'b0;
      for (int i = BAND_SLOTS - 1; i >= 0; i--) begin
         m        = band_field_mask(i);
         pb       = p & m;
         vb       = val & m;
         diff[i]  = fixed[i] && (pb != vb);
         sel[i]   = diff[i] && !seen;
         seen     = seen || diff[i];
         reach[i] = seen;
         if (sel[i]) begin
            go = right ? (pb < vb) : (pb > vb);
         end
      end
      carry[0] = 1'b0;
      x        = p;
      for (int i = 0; i < BAND_SLOTS; i++) begin
         m   = band_field_mask(i);
         pb  = p & m;
         one = m & (~m + DATA_WIDTH'(1));
         full = right ? (pb == '0) : (pb == m);
         carry[i+1] = (go && sel[i]) || (carry[i] && !reach[i] && (!wild[i] || full));
         if (reach[i]) begin
            x = (x & ~m) | (fixed[i] ? (val & m) : (right ? m : '0));
         end else if (wild[i] && carry[i]) begin
            if (full) begin
               x = right ? (x | m) : (x & ~m);
            end else begin
               x = (x & ~m) | ((right ? (pb - one) : (pb + one)) & m);
            end
         end
      end
      res.hit   = !seen;
      res.found = !seen || !carry[BAND_SLOTS];
      if (!seen) begin
         res.value = right ? (p | below) : (p & ~below);
      end else begin
         res.value = x;
      end
      return res;
   endfunction

   // input stage
   logic                   s1_valid_ff, s1_valid_in;
   logic [CMD_WIDTH-1:0]   cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0]  lo_ff, lo_in;
   logic [DATA_WIDTH-1:0]  hi_ff, hi_in;
   logic [DATA_WIDTH-1:0]  val_ff, val_in;
   logic [MASK_WIDTH-1:0]  mask_ff, mask_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   // result stage
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]  out_lo_ff, out_lo_in;
   logic [DATA_WIDTH-1:0]  out_hi_ff, out_hi_in;
   logic                   ok_ff, ok_in;

   logic s2_free;
   logic s1_move;
   logic req_take;

   logic [BAND_SLOTS-1:0] active;
   logic [BAND_SLOTS-1:0] mask_bit;
   logic [BAND_SLOTS-1:0] fixed;
   logic [BAND_SLOTS-1:0] wild;
   logic [DATA_WIDTH-1:0] all_span;
   logic [DATA_WIDTH-1:0] fixed_span;
   logic [DATA_WIDTH-1:0] below_span;
   logic [DATA_WIDTH-1:0] span_lo;
   logic [DATA_WIDTH-1:0] span_hi;
   logic                  open_run;

   border_type nl_lo, pr_lo, nl_hi, pr_hi;
   logic                  good;
   logic [DATA_WIDTH-1:0] min_lo;
   logic [DATA_WIDTH-1:0] min_hi;

   assign s2_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_stall = s1_valid_ff && !s2_free;
   assign req_take  = req_valid && !req_stall;

   for (genvar g = 0; g < BAND_SLOTS; g++) begin : g_band
      if (g < MASK_WIDTH) begin : g_masked
         assign mask_bit[g] = mask_ff[g];
      end else begin : g_open
         assign mask_bit[g] = 1'b0;
      end
      assign active[g] = int'(count_ff) > g;
      assign fixed[g]  = active[g] && mask_bit[g];
      assign wild[g]   = active[g] && !mask_bit[g];
   end

   always_comb begin
      all_span   = '0;
      fixed_span = '0;
      below_span = '0;
      open_run   = 1'b1;
      for (int i = 0; i < BAND_SLOTS; i++) begin
         if (active[i]) begin
            all_span = all_span | band_field_mask(i);
         end
         if (fixed[i]) begin
            fixed_span = fixed_span | band_field_mask(i);
         end
         open_run = open_run && wild[i];
         if (open_run) begin
            below_span = below_span | band_field_mask(i);
         end
      end
      span_lo = val_ff & fixed_span;
      span_hi = span_lo | (all_span & ~fixed_span);
   end

   always_comb begin
      nl_lo = seek_border(lo_ff, val_ff, below_span, fixed, wild, 1'b0);
      pr_lo = seek_border(lo_ff, val_ff, below_span, fixed, wild, 1'b1);
      nl_hi = seek_border(hi_ff, val_ff, below_span, fixed, wild, 1'b0);
      pr_hi = seek_border(hi_ff, val_ff, below_span, fixed, wild, 1'b1);
   end

   always_comb begin
      good   = (nl_lo.hit || nl_lo.found) && (pr_hi.hit || pr_hi.found);
      min_lo = nl_lo.hit ? lo_ff : nl_lo.value;
      min_hi = pr_hi.hit ? hi_ff : pr_hi.value;
      out_lo_in = out_lo_ff;
      out_hi_in = out_hi_ff;
      ok_in     = ok_ff;
      if (s1_move) begin
         case (cmd_ff)
            CMD_OVERLAP: begin
               out_lo_in = '0;
               out_hi_in = '0;
               ok_in     = nl_lo.found && (hi_ff >= nl_lo.value);
            end
            CMD_MIN_COVER: begin
               out_lo_in = good ? min_lo : '0;
               out_hi_in = good ? min_hi : '0;
               ok_in     = good && (min_hi >= min_lo);
            end
            CMD_MAX_COVER: begin
               if (pr_lo.hit) begin
                  out_lo_in = lo_ff;
               end else if (pr_lo.found) begin
                  out_lo_in = pr_lo.value + DATA_WIDTH'(1);
               end else begin
                  out_lo_in = span_lo;
               end
               if (nl_hi.hit) begin
                  out_hi_in = hi_ff;
               end else if (nl_hi.found) begin
                  out_hi_in = nl_hi.value - DATA_WIDTH'(1);
               end else begin
                  out_hi_in = span_hi;
               end
               ok_in = 1'b1;
            end
            default: begin
               out_lo_in = '0;
               out_hi_in = '0;
               ok_in     = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !s2_free);
      rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);
      cmd_in   = req_take ? req_command       : cmd_ff;
      lo_in    = req_take ? req_range_lo      : lo_ff;
      hi_in    = req_take ? req_range_hi      : hi_ff;
      val_in   = req_take ? req_pattern_value : val_ff;
      mask_in  = req_take ? req_band_mask     : mask_ff;
      count_in = req_take ? req_band_count    : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      val_ff    <= val_in;
      mask_ff   <= mask_in;
      count_ff  <= count_in;
      out_lo_ff <= out_lo_in;
      out_hi_ff <= out_hi_in;
      ok_ff     <= ok_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_lo  = out_lo_ff;
   assign rsp_out_hi  = out_hi_ff;
   assign rsp_ok_flag = ok_ff;

endmodule

// File: hdl/tbrc_checker.sv
`include "ternary_band_range_cover_macros.svh"

module tbrc_checker
   import tbrc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic [CMD_WIDTH-1:0]   req_command,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [DATA_WIDTH-1:0]  rsp_out_lo,
   input logic [DATA_WIDTH-1:0]  rsp_out_hi,
   input logic                   rsp_ok_flag
);

   logic req_take;

   assign req_take = req_valid && !req_stall;

   `TBRC_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)
   `TBRC_ASSERT_IMPL(a_stall_needs_word, clock, reset, req_stall, rsp_valid)
   `TBRC_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_lo) && $stable(rsp_out_hi) && $stable(rsp_ok_flag))
   `TBRC_ASSERT_NEXT(a_max_cover_ok, clock, reset, (req_take && req_command == CMD_MAX_COVER) ##1 !rsp_stall, rsp_valid && rsp_ok_flag)
   `TBRC_ASSERT_NEXT(a_no_range_zero, clock, reset, (req_take && (req_command == CMD_OVERLAP || req_command == CMD_UNUSED)) ##1 !rsp_stall, rsp_valid && rsp_out_lo == '0 && rsp_out_hi == '0)

endmodule

bind ternary_band_range_cover tbrc_checker u_tbrc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_command (req_command),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_out_lo  (rsp_out_lo),
   .rsp_out_hi  (rsp_out_hi),
   .rsp_ok_flag (rsp_ok_flag)
);

// File: tb/ternary_band_range_cover_test.sv
import tbrc_pkg::*;

typedef struct packed {
   logic [DATA_WIDTH-1:0] lo;
   logic [DATA_WIDTH-1:0] hi;
   logic                  ok;
} cover_word_type;

class cover_scoreboard;
   cover_word_type        expected_covers[$];
   int                    mismatches;
   int                    unexpected;
   int                    reports;
   int                    checked;
   int                    ok_seen;
   int                    cmd_seen[4];
   logic [DATA_WIDTH-1:0] pat_val;
   logic [MASK_WIDTH-1:0] pat_fixed;
   int                    pat_n;

   function new();
      mismatches = 0;
      unexpected = 0;
      reports    = 0;
      checked    = 0;
      ok_seen    = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
   endfunction

   function logic [DATA_WIDTH-1:0] nibble_mask(int i);
      return ((DATA_WIDTH'(1) << BAND_WIDTH) - DATA_WIDTH'(1)) << (i * BAND_WIDTH);
   endfunction

   // highest fixed band that differs, -1 inside a bank
   function int differing_band(logic [DATA_WIDTH-1:0] p);
      for (int i = pat_n - 1; i >= 0; i--) begin
         if (pat_fixed[i] && ((p ^ pat_val) & nibble_mask(i)) != '0) return i;
      end
      return -1;
   endfunction

   function logic [DATA_WIDTH-1:0] low_wild_bits();
      logic [DATA_WIDTH-1:0] m;
      m = '0;
      for (int i = 0; i < pat_n; i++) begin
         if (pat_fixed[i]) break;
         m |= nibble_mask(i);
      end
      return m;
   endfunction

   function bit bump_up(int from, input logic [DATA_WIDTH-1:0] xi,
                        output logic [DATA_WIDTH-1:0] xo);
      logic [DATA_WIDTH-1:0] m;
      xo = xi;
      for (int i = from; i < pat_n; i++) begin
         m = nibble_mask(i);
         if (pat_fixed[i]) continue;
         if ((xo & m) == m) begin
            xo &= ~m;
         end else begin
            xo += DATA_WIDTH'(1) << (i * BAND_WIDTH);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function bit bump_down(int from, input logic [DATA_WIDTH-1:0] xi,
                          output logic [DATA_WIDTH-1:0] xo);
      logic [DATA_WIDTH-1:0] m;
      xo = xi;
      for (int i = from; i < pat_n; i++) begin
         m = nibble_mask(i);
         if (pat_fixed[i]) continue;
         if ((xo & m) == '0) begin
            xo |= m;
         end else begin
            xo -= DATA_WIDTH'(1) << (i * BAND_WIDTH);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function bit next_bank_start(input logic [DATA_WIDTH-1:0] p,
                                output logic [DATA_WIDTH-1:0] b);
      int                    s;
      logic [DATA_WIDTH-1:0] x, ms, m;
      b = '0;
      s = differing_band(p);
      if (s < 0) begin
         b = p & ~low_wild_bits();
         return 1'b1;
      end
      ms = nibble_mask(s);
      x  = p;
      if ((p & ms) > (pat_val & ms)) begin
         if (!bump_up(s + 1, x, x)) return 1'b0;
      end
      for (int i = 0; i <= s; i++) begin
         m = nibble_mask(i);
         if (pat_fixed[i]) x = (x & ~m) | (pat_val & m);
         else x &= ~m;
      end
      b = x;
      return 1'b1;
   endfunction

   function bit prev_bank_end(input logic [DATA_WIDTH-1:0] p,
                              output logic [DATA_WIDTH-1:0] b);
      int                    s;
      logic [DATA_WIDTH-1:0] x, ms, m;
      b = '0;
      s = differing_band(p);
      if (s < 0) begin
         b = p | low_wild_bits();
         return 1'b1;
      end
      ms = nibble_mask(s);
      x  = p;
      if ((p & ms) < (pat_val & ms)) begin
         if (!bump_down(s + 1, x, x)) return 1'b0;
      end
      for (int i = 0; i <= s; i++) begin
         m = nibble_mask(i);
         if (pat_fixed[i]) x = (x & ~m) | (pat_val & m);
         else x |= m;
      end
      b = x;
      return 1'b1;
   endfunction

   function cover_word_type predict_cover(logic [CMD_WIDTH-1:0] cmd,
                                       logic [DATA_WIDTH-1:0] lo, logic [DATA_WIDTH-1:0] hi,
                                       logic [DATA_WIDTH-1:0] val,
                                       logic [MASK_WIDTH-1:0] mask,
                                       logic [COUNT_WIDTH-1:0] cnt);
      cover_word_type        w;
      logic [MASK_WIDTH:0]   lim;
      logic [DATA_WIDTH-1:0] b, all_bits, fixed_bits, span_lo;
      bit                    good;
      w        = '0;
      pat_n    = (cnt > BAND_SLOTS) ? BAND_SLOTS : int'(cnt);
      pat_val  = val;
      lim      = ((MASK_WIDTH + 1)'(1) << pat_n) - (MASK_WIDTH + 1)'(1);
      pat_fixed = mask & lim[MASK_WIDTH-1:0];
      all_bits   = '0;
      fixed_bits = '0;
      for (int i = 0; i < pat_n; i++) begin
         all_bits |= nibble_mask(i);
         if (pat_fixed[i]) fixed_bits |= nibble_mask(i);
      end
      case (cmd)
         CMD_OVERLAP: begin
            if (next_bank_start(lo, b)) w.ok = (hi >= b);
         end
         CMD_MIN_COVER: begin
            good = 1'b1;
            if (differing_band(lo) >= 0) begin
               if (next_bank_start(lo, b)) lo = b;
               else good = 1'b0;
            end
            if (good && differing_band(hi) >= 0) begin
               if (prev_bank_end(hi, b)) hi = b;
               else good = 1'b0;
            end
            if (good) begin
               w.lo = lo;
               w.hi = hi;
               w.ok = (hi >= lo);
            end
         end
         CMD_MAX_COVER: begin
            span_lo = val & fixed_bits;
            if (differing_band(lo) >= 0) begin
               if (prev_bank_end(lo, b)) lo = b + DATA_WIDTH'(1);
               else lo = span_lo;
            end
            if (differing_band(hi) >= 0) begin
               if (next_bank_start(hi, b)) hi = b - DATA_WIDTH'(1);
               else hi = span_lo | (all_bits & ~fixed_bits);
            end
            w.lo = lo;
            w.hi = hi;
            w.ok = 1'b1;
         end
         default: w = '0;
      endcase
      return w;
   endfunction

   function void note_word(logic [CMD_WIDTH-1:0] cmd, logic [DATA_WIDTH-1:0] lo,
                           logic [DATA_WIDTH-1:0] hi, logic [DATA_WIDTH-1:0] val,
                           logic [MASK_WIDTH-1:0] mask, logic [COUNT_WIDTH-1:0] cnt);
      cmd_seen[cmd]++;
      expected_covers.push_back(predict_cover(cmd, lo, hi, val, mask, cnt));
   endfunction

   function void check_word(logic [DATA_WIDTH-1:0] lo, logic [DATA_WIDTH-1:0] hi, logic ok);
      cover_word_type want;
      if (expected_covers.size() == 0) begin
         unexpected++;
         if (reports < 10) begin
            reports++;
            $display("unexpected rsp word: lo %h hi %h ok %b", lo, hi, ok);
         end
         return;
      end
      want = expected_covers.pop_front();
      checked++;
      if (ok === 1'b1) ok_seen++;
      if (lo !== want.lo || hi !== want.hi || ok !== want.ok) begin
         mismatches++;
         if (reports < 10) begin
            reports++;
            $display("rsp word %0d mismatch: expected lo %h hi %h ok %b, got lo %h hi %h ok %b",
                     checked, want.lo, want.hi, want.ok, lo, hi, ok);
         end
      end
   endfunction

   function int pending();
      return expected_covers.size();
   endfunction

   function int failures();
      return mismatches + unexpected + expected_covers.size();
   endfunction
endclass

module ternary_band_range_cover_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_WORDS = 2000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [CMD_WIDTH-1:0]   req_command = CMD_OVERLAP;
   logic [DATA_WIDTH-1:0]  req_range_lo = '0;
   logic [DATA_WIDTH-1:0]  req_range_hi = '0;
   logic [DATA_WIDTH-1:0]  req_pattern_value = '0;
   logic [MASK_WIDTH-1:0]  req_band_mask = '0;
   logic [COUNT_WIDTH-1:0] req_band_count = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [DATA_WIDTH-1:0]  rsp_out_lo;
   logic [DATA_WIDTH-1:0]  rsp_out_hi;
   logic                   rsp_ok_flag;

   cover_scoreboard sb;
   int  rx_mode = 1;
   bit  hold_wanted = 1'b0;
   int  hold_left = 0;
   int  rx_cycle = 0;
   int  quiet = 0;

   ternary_band_range_cover u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_range_lo      (req_range_lo),
      .req_range_hi      (req_range_hi),
      .req_pattern_value (req_pattern_value),
      .req_band_mask     (req_band_mask),
      .req_band_count    (req_band_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_lo        (rsp_out_lo),
      .rsp_out_hi        (rsp_out_hi),
      .rsp_ok_flag       (rsp_ok_flag)
   );

   always #1 clock = ~clock;

   task automatic send_word(input logic [CMD_WIDTH-1:0] cmd, input logic [DATA_WIDTH-1:0] lo,
                            input logic [DATA_WIDTH-1:0] hi, input logic [DATA_WIDTH-1:0] val,
                            input logic [MASK_WIDTH-1:0] mask,
                            input logic [COUNT_WIDTH-1:0] cnt);
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_range_lo      <= lo;
      req_range_hi      <= hi;
      req_pattern_value <= val;
      req_band_mask     <= mask;
      req_band_count    <= cnt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_word(cmd, lo, hi, val, mask, cnt);
   endtask

   task automatic idle_cycles(input int k);
      if (k > 0) begin
         req_valid <= 1'b0;
         repeat (k) @(posedge clock);
      end
   endtask

   // random point, biased towards banks, bank borders and near misses
   function automatic logic [DATA_WIDTH-1:0] pick_point(input logic [DATA_WIDTH-1:0] val,
                                                        input logic [MASK_WIDTH-1:0] mask,
                                                        input logic [COUNT_WIDTH-1:0] cnt);
      logic [DATA_WIDTH-1:0] fb, r, p, edge_pt;
      int                    n, k;
      fb = '0;
      n  = (cnt > BAND_SLOTS) ? BAND_SLOTS : int'(cnt);
      for (int i = 0; i < n; i++) begin
         if (mask[i]) fb |= ((DATA_WIDTH'(1) << BAND_WIDTH) - DATA_WIDTH'(1)) << (i * BAND_WIDTH);
      end
      r = $urandom;
      p = (r & ~fb) | (val & fb);
      case ($urandom_range(0, 4))
         0: return r;
         1: return p;
         2: begin
            edge_pt = ((r[0] ? '1 : '0) & ~fb) | (val & fb);
            return edge_pt + DATA_WIDTH'($urandom_range(0, 2)) - DATA_WIDTH'(1);
         end
         3: begin
            k = $urandom_range(0, BAND_SLOTS - 1);
            p[k*BAND_WIDTH +: BAND_WIDTH] = BAND_WIDTH'($urandom);
            return p;
         end
         default: return p ^ (DATA_WIDTH'(1) << $urandom_range(0, DATA_WIDTH - 1));
      endcase
   endfunction

   task automatic send_random();
      logic [CMD_WIDTH-1:0]   cmd;
      logic [DATA_WIDTH-1:0]  lo, hi, val, tmp;
      logic [MASK_WIDTH-1:0]  mask;
      logic [COUNT_WIDTH-1:0] cnt;
      if ($urandom_range(0, 19) == 0) cmd = CMD_UNUSED;
      else begin
         case ($urandom_range(0, 2))
            0: cmd = CMD_OVERLAP;
            1: cmd = CMD_MIN_COVER;
            default: cmd = CMD_MAX_COVER;
         endcase
      end
      if ($urandom_range(0, 7) == 0) cnt = COUNT_WIDTH'($urandom);
      else cnt = COUNT_WIDTH'($urandom_range(1, MAX_BAND_COUNT));
      val  = $urandom;
      mask = MASK_WIDTH'($urandom);
      lo   = pick_point(val, mask, cnt);
      hi   = pick_point(val, mask, cnt);
      if (lo > hi && $urandom_range(0, 4) != 0) begin
         tmp = lo;
         lo  = hi;
         hi  = tmp;
      end
      send_word(cmd, lo, hi, val, mask, cnt);
   endtask

   // receiver stall pattern, with one long hold-off on request
   always @(posedge clock) begin
      rx_cycle++;
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_wanted) begin
         hold_wanted = 1'b0;
         hold_left   = HOLD_CYCLES - 1;
         rsp_stall  <= 1'b1;
      end else begin
         case (rx_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            2: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= ((rx_cycle % 11) < 4);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_out_lo, rsp_out_hi, rsp_ok_flag);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", quiet);
         $display("[ternary_band_range_cover] ERROR");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      int burst_left;
      int phase;
      sb = new();
      burst_left = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words
      send_word(CMD_OVERLAP, 32'h0, 32'hFFFF_FFFF, 32'h0, 8'h00, 4'd8);
      send_word(CMD_MIN_COVER, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 8'hFF, 4'd8);
      send_word(CMD_MAX_COVER, 32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 8'hFF, 4'd8);
      send_word(CMD_UNUSED, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h5555_AAAA, 8'h3C, 4'd5);
      send_word(CMD_MIN_COVER, 32'h5, 32'h3, 32'hAAAA_AAAA, 8'hFF, 4'd0);
      send_word(CMD_MAX_COVER, 32'h1000, 32'hFFFF_0000, 32'h5A5A_5A5A, 8'hA5, 4'd15);
      send_word(CMD_OVERLAP, 32'h123, 32'h456, 32'h300, 8'hFF, 4'd3);
      send_word(CMD_MIN_COVER, 32'h2000_0000, 32'hFFFF_FFFF, 32'h1000_0000, 8'h80, 4'd8);
      send_word(CMD_MIN_COVER, 32'h0, 32'h0FFF_FFFF, 32'h1000_0000, 8'h80, 4'd8);
      send_word(CMD_MIN_COVER, 32'h61, 32'h6F, 32'h50, 8'h02, 4'd8);
      send_word(CMD_MAX_COVER, 32'h3, 32'hFFFF_FFF0, 32'h5, 8'h01, 4'd8);
      send_word(CMD_MAX_COVER, 32'h5, 32'hFFFF_FFFF, 32'h5, 8'h01, 4'd8);
      send_word(CMD_MAX_COVER, 32'h50, 32'h5F, 32'h50, 8'h02, 4'd2);
      send_word(CMD_OVERLAP, 32'h61, 32'h14F, 32'h50, 8'h02, 4'd8);
      send_word(CMD_OVERLAP, 32'h61, 32'h150, 32'h50, 8'h02, 4'd8);
      send_word(CMD_OVERLAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'd8);
      send_word(CMD_MIN_COVER, 32'h1234_5670, 32'h1234_567F, 32'h9, 8'h01, 4'd1);
      send_word(CMD_MAX_COVER, 32'h0000_0100, 32'hF000_0000, 32'h0F0F_0F0F, 8'h55, 4'd9);
      send_word(CMD_UNUSED, 32'h0, 32'h0, 32'h0, 8'h00, 4'd0);
      send_word(CMD_OVERLAP, 32'h0, 32'hFFFF_FFFF, 32'hF000_0000, 8'h80, 4'd8);

      for (int k = 0; k < RANDOM_WORDS; k++) begin
         phase   = k / 250;
         rx_mode = phase % 4;
         if (k == 700) hold_wanted = 1'b1;
         if (k == 1300) begin
            // drain before carrying on
            req_valid <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
         end
         send_random();
         if (burst_left == 0) begin
            if (phase % 2 == 1) idle_cycles($urandom_range(0, 12));
            else idle_cycles($urandom_range(0, 2));
            burst_left = $urandom_range(1, 40);
         end else begin
            burst_left--;
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("checked %0d rsp words: %0d overlap, %0d minimal, %0d maximal, %0d unused command",
               sb.checked, sb.cmd_seen[CMD_OVERLAP], sb.cmd_seen[CMD_MIN_COVER],
               sb.cmd_seen[CMD_MAX_COVER], sb.cmd_seen[CMD_UNUSED]);
      $display("%0d words with ok set, one %0d-cycle rsp hold-off, one full drain, %0d mismatches",
               sb.ok_seen, HOLD_CYCLES, sb.mismatches + sb.unexpected);
      if (sb.failures() == 0) begin
         $display("[ternary_band_range_cover] OK");
      end else begin
         $display("[ternary_band_range_cover] ERROR");
      end
      $finish;
   end
endmodule

// File: ternary_band_range_cover.f
+incdir+hdl
hdl/tbrc_pkg.sv
hdl/ternary_band_range_cover.sv
hdl/tbrc_checker.sv
tb/ternary_band_range_cover_test.sv
